FILE: hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Field widths, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CMD_W     = 1;
  localparam int KEY_W     = 31;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;

  // request opcodes
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DELETED  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;   // clear one slot of the table after reset
    logic load;       // capture a new request
    logic mod_step;   // one step of the key modulo slot count pipe
    logic probe_chk;  // check the probed slot, store or advance
    logic scan_step;  // one step of the delete scan
    logic finish;     // load the response register
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic probe_empty;
    logic probe_last;
    logic scan_last;
  } dp_sts_t;

endpackage

FILE: hdl/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top: open-addressing hash table, linear probing
// Insert stores a value at the first free slot from key mod SLOTS; delete
// clears every slot holding the request's value and reports the count.
// ----------------------------------------------------------------------------
// Insert: key modulo by reciprocal multiply, then up to SLOTS probes through
//   the slot memory's registered read port.
// Delete: pipelined scan of every slot through the same port.
// The response is then loaded (held off while a stalled response waits);
//   one request is in flight, the next is taken the cycle after the load.
// After reset the table is cleared one slot per cycle, with requests stalled.
module linear_probe_hash_table_top #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [lpht_pkg::CMD_W-1:0]      cmd,
  input  logic [lpht_pkg::KEY_W-1:0]      key,
  input  logic [lpht_pkg::VAL_W-1:0]      value,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [lpht_pkg::STATUS_W-1:0]   status,
  output logic [lpht_pkg::SLOT_W-1:0]     home_slot,
  output logic [lpht_pkg::SLOT_W-1:0]     placed_slot,
  output logic [lpht_pkg::COUNT_W-1:0]    removed_count
);
  import lpht_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // sequencing
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_cmd   (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // storage and arithmetic
  lpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .req_cmd       (cmd),
    .req_key       (key),
    .req_value     (value),
    .status        (status),
    .home_slot     (home_slot),
    .placed_slot   (placed_slot),
    .removed_count (removed_count)
  );

endmodule

FILE: hdl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl: sequencing state machine
// Runs the clearing pass, then steps each request through hash, probe or
// scan, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [lpht_pkg::CMD_W-1:0]    req_cmd,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lpht_pkg::dp_ctl_t             ctl,
  input  lpht_pkg::dp_sts_t             sts
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;
  logic   rsp_free;

  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // decode commands for the datapath
  always_comb begin
    ctl           = '0;
    ctl.clr_step  = (state == ST_CLEAR);
    ctl.load      = (state == ST_IDLE) && req_valid;
    ctl.mod_step  = (state == ST_MOD);
    ctl.probe_chk = (state == ST_PROBE_CHK);
    ctl.scan_step = (state == ST_SCAN);
    ctl.finish    = (state == ST_FINISH) && rsp_free;
  end

  // hold state and the response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      // raise on a new response, drop once the held one is taken
      if (ctl.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (sts.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            state <= (req_cmd == CMD_DELETE) ? ST_SCAN : ST_MOD;
          end
        end
        ST_MOD: begin
          if (sts.mod_last) begin
            state <= ST_PROBE_RD;
          end
        end
        ST_PROBE_RD: begin
          state <= ST_PROBE_CHK;
        end
        ST_PROBE_CHK: begin
          if (sts.probe_empty || sts.probe_last) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_PROBE_RD;
          end
        end
        ST_SCAN: begin
          if (sts.scan_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp: table storage and arithmetic
// Slot memory with a valid bit per entry, reciprocal-multiply key modulo
// unit, probe and scan counters, and the response register.
// ----------------------------------------------------------------------------
module lpht_dp #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpht_pkg::dp_ctl_t               ctl,
  output lpht_pkg::dp_sts_t               sts,
  input  logic [lpht_pkg::CMD_W-1:0]      req_cmd,
  input  logic [lpht_pkg::KEY_W-1:0]      req_key,
  input  logic [lpht_pkg::VAL_W-1:0]      req_value,
  output logic [lpht_pkg::STATUS_W-1:0]   status,
  output logic [lpht_pkg::SLOT_W-1:0]     home_slot,
  output logic [lpht_pkg::SLOT_W-1:0]     placed_slot,
  output logic [lpht_pkg::COUNT_W-1:0]    removed_count
);
  import lpht_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int RW  = IW + 1;
  localparam int SH  = KEY_W + IW;
  localparam int MW  = KEY_W + 1;

  localparam logic [CW-1:0]    SLOTS_C  = CW'(SLOTS);
  localparam logic [CW-1:0]    LAST_C   = CW'(SLOTS - 1);
  localparam logic [IW-1:0]    LAST_IDX = IW'(SLOTS - 1);
  localparam logic [RW-1:0]    SLOTS_R  = RW'(SLOTS);
  localparam logic [KEY_W-1:0] SLOTS_K  = KEY_W'(SLOTS);
  // floor(2^SH / SLOTS): quotient estimate is low by at most one
  localparam logic [MW-1:0]    RECIP    = MW'((64'd1 << SH) / 64'(SLOTS));
  localparam logic [1:0]       MOD_LAST = 2'd2;

  // entry: {valid, value}
  logic [VAL_W:0]     mem [SLOTS];
  logic [VAL_W:0]     rd_data;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [VAL_W:0]     wr_data;

  logic [CMD_W-1:0]   op;
  logic [KEY_W-1:0]   kreg;
  logic [VAL_W-1:0]   val;
  logic [IW-1:0]      rem;
  logic [1:0]         mstage;
  logic [KEY_W+MW-1:0] prod;
  logic [RW-1:0]      rem_raw;
  logic [IW-1:0]      idx;
  logic [CW-1:0]      cnt;
  logic               found;
  logic [IW-1:0]      placed;
  logic [CW-1:0]      removed;
  logic               pend;
  logic [IW-1:0]      pend_addr;

  logic [KEY_W-1:0]   quo;
  logic [RW-1:0]      rem_next;
  logic               empty;
  logic               match;
  logic [IW+SLOT_W-1:0]  home_ext;
  logic [IW+SLOT_W-1:0]  placed_ext;
  logic [CW+COUNT_W-1:0] removed_ext;

  // key modulo slot count: estimate quotient, subtract, correct once
  assign quo      = KEY_W'(prod >> SH);
  assign rem_next = (rem_raw >= SLOTS_R) ? (rem_raw - SLOTS_R) : rem_raw;

  assign empty = ~rd_data[VAL_W];
  assign match = pend && rd_data[VAL_W] && (rd_data[VAL_W-1:0] == val);

  assign sts.clr_last    = (cnt == LAST_C);
  assign sts.mod_last    = (mstage == MOD_LAST);
  assign sts.probe_empty = empty;
  assign sts.probe_last  = (cnt == LAST_C);
  assign sts.scan_last   = (cnt == SLOTS_C);

  assign home_ext    = {{SLOT_W{1'b0}}, rem};
  assign placed_ext  = {{SLOT_W{1'b0}}, placed};
  assign removed_ext = {{COUNT_W{1'b0}}, removed};

  // select the memory access for this cycle
  assign rd_addr = ctl.scan_step ? cnt[IW-1:0] : idx;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {1'b1, val};
    if (ctl.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt[IW-1:0];
      wr_data = '0;
    end else if (ctl.probe_chk && empty) begin
      wr_en   = 1'b1;
    end else if (ctl.scan_step && match) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = '0;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (ctl.clr_step) begin
      cnt <= sts.clr_last ? '0 : cnt + 1'b1;
    end else if (ctl.load) begin
      cnt   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (ctl.probe_chk) begin
      if (empty) begin
        found <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (ctl.scan_step) begin
      pend <= (cnt != SLOTS_C);
      cnt  <= cnt + 1'b1;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op      <= req_cmd;
      kreg    <= req_key;
      val     <= req_value;
      rem     <= '0;
      mstage  <= '0;
      removed <= '0;
    end
    // advance the three-stage modulo pipe; the last stage lands the result
    if (ctl.mod_step) begin
      prod    <= kreg * RECIP;
      rem_raw <= RW'(kreg - quo * SLOTS_K);
      rem     <= rem_next[IW-1:0];
      idx     <= rem_next[IW-1:0];
      mstage  <= mstage + 1'b1;
    end
    if (ctl.probe_chk) begin
      if (empty) begin
        placed <= idx;
      end else begin
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
    end
    if (ctl.scan_step) begin
      pend_addr <= cnt[IW-1:0];
      if (match) begin
        removed <= removed + 1'b1;
      end
    end
  end

  // load the response register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      if (op == CMD_DELETE) begin
        status        <= STATUS_DELETED;
        home_slot     <= '0;
        placed_slot   <= '0;
        removed_count <= removed_ext[COUNT_W-1:0];
      end else begin
        status        <= found ? STATUS_INSERTED : STATUS_FULL;
        home_slot     <= home_ext[SLOT_W-1:0];
        placed_slot   <= found ? placed_ext[SLOT_W-1:0] : '0;
        removed_count <= '0;
      end
    end
  end

endmodule

FILE: hdl/lpht_check.sv
// ----------------------------------------------------------------------------
// lpht_check: port-level checks for the hash table
// Watches handshakes and response fields of the top level over time.
// ----------------------------------------------------------------------------
module lpht_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic [lpht_pkg::STATUS_W-1:0]   status,
  input logic [lpht_pkg::SLOT_W-1:0]     home_slot,
  input logic [lpht_pkg::SLOT_W-1:0]     placed_slot,
  input logic [lpht_pkg::COUNT_W-1:0]    removed_count
);
  import lpht_pkg::*;

  // a stalled response holds its status
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
    else $error("stalled response changed");

  // one request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // delete reports no slot numbers
  a_del_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_DELETED |-> home_slot == '0 && placed_slot == '0)
    else $error("delete response carries slot numbers");

  // insert reports no removals, full reports no placement
  a_ins_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STATUS_INSERTED || status == STATUS_FULL) |->
      removed_count == '0 && (status == STATUS_INSERTED || placed_slot == '0))
    else $error("insert response fields inconsistent");

endmodule

bind linear_probe_hash_table_top lpht_check u_check (.*);
